// File: design/lrus_pkg.sv
// Shared types and fixed widths for the LRU recency-stack page replacement block.
package lrus_pkg;

   // Widths fixed by the port definition.
   localparam int PAGE_PORT_W = 16;
   localparam int CFG_W       = 5;
   localparam int COUNT_W     = 32;

   // Frame count after reset.
   localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd4;

   // Per-cycle control broadcast from the top level to every stack cell.
   typedef struct packed {
      logic step;    // a reference beat is accepted this cycle
      logic clear;   // that beat carries a restart
   } cell_ctl_type;

endpackage

// File: design/lrus_cell.sv
// One entry of the recency stack: compares, passes its match flag on and shifts down.
module lrus_cell #(
   parameter int INDEX     = 0,
   parameter int PAGE_BITS = 16,
   parameter int DEPTH_W   = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lrus_pkg::cell_ctl_type    ctl,
   input  logic [DEPTH_W-1:0]        depth,
   input  logic [PAGE_BITS-1:0]      ref_page,
   input  logic [PAGE_BITS-1:0]      prev_page,
   input  logic                      prev_valid,
   input  logic                      seen_in,
   output logic                      seen_out,
   output logic [PAGE_BITS-1:0]      page_out,
   output logic                      valid_out,
   output logic                      bottom_valid,
   output logic [PAGE_BITS-1:0]      bottom_page
);
   import lrus_pkg::*;

   logic [PAGE_BITS-1:0] page_ff;
   logic [PAGE_BITS-1:0] page_in;
   logic                 valid_ff;
   logic                 valid_in;
   logic                 valid_eff;
   logic                 active;
   logic                 is_bottom;
   logic                 match;
   logic                 shift;

   // A restart empties the entry before the reference is looked up.
   assign valid_eff = valid_ff & ~ctl.clear;
   assign active    = DEPTH_W'(INDEX) < depth;
   assign is_bottom = DEPTH_W'(INDEX + 1) == depth;
   assign match     = active & valid_eff & (page_ff == ref_page);

   // Entries down to and including the first match shift; on a miss every active one does.
   assign shift    = active & ~seen_in;
   assign seen_out = seen_in | match;

   assign page_out     = page_ff;
   assign valid_out    = valid_eff;
   assign bottom_valid = is_bottom & valid_eff;
   assign bottom_page  = (is_bottom & valid_eff) ? page_ff : '0;

   // Next contents of the entry.
   always_comb begin
      page_in  = page_ff;
      valid_in = valid_ff;
      if (ctl.step) begin
         if (shift) begin
            page_in  = prev_page;
            valid_in = prev_valid;
         end else begin
            valid_in = valid_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

endmodule

// File: design/lru_stack_page_replacement.sv
// Top level of the true-LRU page replacement block built as a row of stack cells.
//
//   Channel   Direction  Handshake              Beat contents
//   req_      in         req_valid/req_ready    req_page, req_restart
//   rsp_      out        rsp_valid/rsp_ready    rsp_hit, rsp_evicted_valid,
//                                               rsp_evicted_page, rsp_fault_count
//   csr_      in         csr_we (no wait)       csr_wdata = active frame count
//
// The cells compare and shift at the accepting edge, and the result is captured in the
// output register at that same edge. A new reference is taken every cycle while the
// output register is empty or being drained; the rate is set by the single
// compare-and-shift pass through the cell row.
// Reset is synchronous and active high; it empties all frames, clears the fault
// count and sets the frame count to four. A stalled result holds req_ready low.
module lru_stack_page_replacement #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lrus_pkg::PAGE_PORT_W-1:0] req_page,
   input  logic                            req_restart,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_hit,
   output logic                            rsp_evicted_valid,
   output logic [lrus_pkg::PAGE_PORT_W-1:0] rsp_evicted_page,
   output logic [lrus_pkg::COUNT_W-1:0]     rsp_fault_count,
   input  logic                            csr_we,
   input  logic [lrus_pkg::CFG_W-1:0]       csr_wdata
);
   import lrus_pkg::*;

   localparam int DEPTH_W = $clog2(MAX_FRAMES + 1);

   logic [CFG_W-1:0]     frames_ff;
   logic [DEPTH_W-1:0]   depth;
   logic [31:0]          frames_wide;
   logic [31:0]          page_wide;
   logic [PAGE_BITS-1:0] ref_page;
   cell_ctl_type         ctl;
   logic                 accept;

   logic [PAGE_BITS-1:0] prev_page    [MAX_FRAMES];
   logic                 prev_valid   [MAX_FRAMES];
   logic [PAGE_BITS-1:0] cell_page    [MAX_FRAMES];
   logic                 cell_valid   [MAX_FRAMES];
   logic                 bot_valid    [MAX_FRAMES];
   logic [PAGE_BITS-1:0] bot_page     [MAX_FRAMES];
   logic                 seen         [MAX_FRAMES+1];

   logic                 hit;
   logic                 ev_valid;
   logic [PAGE_BITS-1:0] ev_page;
   logic [31:0]          ev_page_wide;
   logic [COUNT_W-1:0]   count_base;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 hit_ff;
   logic                 ev_valid_ff;
   logic [PAGE_PORT_W-1:0] ev_page_ff;
   logic [COUNT_W-1:0]   fault_count_ff;
   logic [COUNT_W-1:0]   fault_count_in;

   // Frame count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_RESET;
      end else if (csr_we) begin
         frames_ff <= csr_wdata;
      end
   end

   // Clamp the frame count into one to MAX_FRAMES.
   always_comb begin
      frames_wide = {{(32 - CFG_W){1'b0}}, frames_ff};
      if (frames_wide == 32'd0) begin
         depth = DEPTH_W'(1);
      end else if (frames_wide > 32'(MAX_FRAMES)) begin
         depth = DEPTH_W'(MAX_FRAMES);
      end else begin
         depth = frames_wide[DEPTH_W-1:0];
      end
   end

   // Only the low PAGE_BITS of the page number take part.
   assign page_wide = {{(32 - PAGE_PORT_W){1'b0}}, req_page};
   assign ref_page  = page_wide[PAGE_BITS-1:0];

   assign req_ready  = ~rsp_valid_ff | rsp_ready;
   assign accept     = req_valid & req_ready;
   assign ctl        = '{step: accept, clear: req_restart};

   // The row of cells; the top one takes the referenced page.
   assign seen[0] = 1'b0;
   for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
      if (i == 0) begin : g_top
         assign prev_page[i]  = ref_page;
         assign prev_valid[i] = 1'b1;
      end else begin : g_rest
         assign prev_page[i]  = cell_page[i-1];
         assign prev_valid[i] = cell_valid[i-1];
      end

      lrus_cell #(
         .INDEX     (i),
         .PAGE_BITS (PAGE_BITS),
         .DEPTH_W   (DEPTH_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .depth        (depth),
         .ref_page     (ref_page),
         .prev_page    (prev_page[i]),
         .prev_valid   (prev_valid[i]),
         .seen_in      (seen[i]),
         .seen_out     (seen[i+1]),
         .page_out     (cell_page[i]),
         .valid_out    (cell_valid[i]),
         .bottom_valid (bot_valid[i]),
         .bottom_page  (bot_page[i])
      );
   end

   assign hit = seen[MAX_FRAMES];

   // Gather the bottom active entry; exactly one cell is the bottom.
   always_comb begin
      ev_valid = 1'b0;
      ev_page  = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         ev_valid = ev_valid | bot_valid[i];
         ev_page  = ev_page | bot_page[i];
      end
      if (hit) begin
         ev_valid = 1'b0;
         ev_page  = '0;
      end
   end
   assign ev_page_wide = 32'(ev_page);

   // Saturating miss counter, cleared by a restart beat.
   always_comb begin
      count_base     = req_restart ? '0 : fault_count_ff;
      fault_count_in = fault_count_ff;
      if (accept) begin
         fault_count_in = count_base;
         if (!hit && count_base != {COUNT_W{1'b1}}) begin
            fault_count_in = count_base + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_count_ff <= '0;
      end else begin
         fault_count_ff <= fault_count_in;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff      <= hit;
         ev_valid_ff <= ev_valid;
         ev_page_ff  <= ev_page_wide[PAGE_PORT_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_page  = ev_page_ff;
   assign rsp_fault_count   = fault_count_ff;

   // A restart beat leaves at most its own miss in the counter.
   a_restart_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_restart |=> fault_count_ff == '0 || fault_count_ff == COUNT_W'(1))
      else $error("fault count not cleared by restart");

   // A hit never reports an eviction.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && hit_ff |-> !ev_valid_ff)
      else $error("eviction reported on a hit");

   // Without a valid eviction the evicted page reads as zero.
   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !ev_valid_ff |-> ev_page_ff == '0)
      else $error("evicted page not zero");

   // The referenced page is the most recent entry after every beat, unless a
   // restart presented in the following cycle already masks it.
   a_top_loaded: assert property (@(posedge clock) disable iff (reset)
      accept |=> cell_valid[0] || req_restart)
      else $error("top entry not valid after a reference");

   // Without restart the counter never goes down.
   a_count_monotone: assert property (@(posedge clock) disable iff (reset)
      accept && !req_restart |=> fault_count_ff >= $past(fault_count_ff))
      else $error("fault count decreased");

endmodule
